// ----- hdl/rrdl_pkg.sv -----
package rrdl_pkg;

  // Pipeline advance strobe shared by the arithmetic sections
  typedef logic pipe_en_t;

  // Modulus of the dropped residue after reset
  localparam int LAST_MODULUS_RESET = 2;

endpackage

// ----- hdl/rrdl_mod_reduce.sv -----
module rrdl_mod_reduce #(
  parameter int W = 62
) (
  input  logic             clk,
  input  rrdl_pkg::pipe_en_t en,
  input  logic [W-1:0]     a_i,
  input  logic [W-1:0]     m_i,
  output logic [W-1:0]     r_o,
  output logic [W-1:0]     m_o
);
  import rrdl_pkg::*;

  // Restoring reduction, one dividend bit per stage, MSB first
  logic [W-1:0] rem_r [W];
  logic [W-1:0] rem_nxt [W];
  logic [W-1:0] val_r [W];
  logic [W-1:0] val_nxt [W];
  logic [W-1:0] m_r [W];
  logic [W-1:0] m_nxt [W];
  logic [W:0]   sh_w [W];
  logic [W:0]   diff_w [W];

  always_comb begin
    for (int s = 0; s < W; s++) begin
      if (s == 0) begin
        sh_w[s]   = {{W{1'b0}}, a_i[W-1]};
        val_nxt[s] = a_i << 1;
        m_nxt[s]   = m_i;
      end else begin
        sh_w[s]   = {rem_r[s-1], val_r[s-1][W-1]};
        val_nxt[s] = val_r[s-1] << 1;
        m_nxt[s]   = m_r[s-1];
      end
      diff_w[s] = sh_w[s] - {1'b0, m_nxt[s]};
      if (sh_w[s] >= {1'b0, m_nxt[s]}) begin
        rem_nxt[s] = diff_w[s][W-1:0];
      end else begin
        rem_nxt[s] = sh_w[s][W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < W; s++) begin
        rem_r[s] <= rem_nxt[s];
        val_r[s] <= val_nxt[s];
        m_r[s]   <= m_nxt[s];
      end
    end
  end

  // Zero modulus reduces everything to zero
  assign r_o = (m_r[W-1] == '0) ? '0 : rem_r[W-1];
  assign m_o = m_r[W-1];

endmodule

// ----- hdl/rrdl_mod_mul.sv -----
module rrdl_mod_mul #(
  parameter int W = 62
) (
  input  logic             clk,
  input  rrdl_pkg::pipe_en_t en,
  input  logic [W-1:0]     a_i,
  input  logic [W-1:0]     b_i,
  input  logic [W-1:0]     m_i,
  output logic [W-1:0]     r_o
);
  import rrdl_pkg::*;

  // Shift-and-add modular product, one multiplier bit per stage, MSB first
  logic [W-1:0] r_r [W];
  logic [W-1:0] r_nxt [W];
  logic [W-1:0] a_r [W];
  logic [W-1:0] a_nxt [W];
  logic [W-1:0] b_r [W];
  logic [W-1:0] b_nxt [W];
  logic [W-1:0] m_r [W];
  logic [W-1:0] m_nxt [W];
  logic [W-1:0] rp_w [W];
  logic [W:0]   dbl_w [W];
  logic [W-1:0] dr_w [W];
  logic [W:0]   add_w [W];

  always_comb begin
    for (int s = 0; s < W; s++) begin
      if (s == 0) begin
        rp_w[s]  = '0;
        a_nxt[s] = a_i;
        b_nxt[s] = b_i;
        m_nxt[s] = m_i;
      end else begin
        rp_w[s]  = r_r[s-1];
        a_nxt[s] = a_r[s-1];
        b_nxt[s] = b_r[s-1] << 1;
        m_nxt[s] = m_r[s-1];
      end
      dbl_w[s] = {1'b0, rp_w[s]} + {1'b0, rp_w[s]};
      if (dbl_w[s] >= {1'b0, m_nxt[s]}) begin
        dr_w[s] = W'(dbl_w[s] - {1'b0, m_nxt[s]});
      end else begin
        dr_w[s] = dbl_w[s][W-1:0];
      end
      add_w[s] = {1'b0, dr_w[s]} + {1'b0, a_nxt[s]};
      if (!b_nxt[s][W-1]) begin
        r_nxt[s] = dr_w[s];
      end else if (add_w[s] >= {1'b0, m_nxt[s]}) begin
        r_nxt[s] = W'(add_w[s] - {1'b0, m_nxt[s]});
      end else begin
        r_nxt[s] = add_w[s][W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < W; s++) begin
        r_r[s] <= r_nxt[s];
        a_r[s] <= a_nxt[s];
        b_r[s] <= b_nxt[s];
        m_r[s] <= m_nxt[s];
      end
    end
  end

  assign r_o = r_r[W-1];

endmodule

// ----- hdl/rns_rescale_drop_last_modulus_top.sv -----
// Rounded division of an RNS coefficient by the last modulus. Each request carries a residue,
// the same coefficient's residue modulo the last modulus, the kept modulus and the inverse of
// the last modulus; the result is the residue of the rounded quotient with an error flag in
// tuser. One request is taken every cycle while the output is not stalled. The pipeline holds
// 3*MODULUS_BITS+4 register stages, most of them in the two bit-serial reduction sections and
// the shift-add modular multiplier, each one bit per pipeline stage. A stalled output freezes
// the whole pipeline. The user must write last_modulus over cfg_wen/cfg_wdata only while no
// request is in flight; the block itself does not enforce it.
module rns_rescale_drop_last_modulus_top #(
  parameter int MODULUS_BITS = 62
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // residue, last_residue, kept_modulus, last_inverse (lowest bits first), zero padded
  input  logic [((4*MODULUS_BITS+7)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // rescaled_residue, zero padded
  output logic [((MODULUS_BITS+7)/8)*8-1:0] out_tdata,
  // range_error
  output logic out_tuser,
  input  logic cfg_wen,
  input  logic [MODULUS_BITS-1:0] cfg_wdata
);
  import rrdl_pkg::*;

  localparam int W      = MODULUS_BITS;
  localparam int OUT_TW = ((MODULUS_BITS+7)/8)*8;
  localparam int LAT    = 3*W + 4;
  localparam int SIDE_W = 3*W + 1;

  pipe_en_t       en;
  logic [LAT-1:0] vld_r;
  logic [W-1:0]   ql_r;
  logic [W-1:0]   h_w;

  logic [W-1:0] c_in, cl_in, qi_in, inv_in;
  logic [W-1:0] c0_r, cl0_r, qi0_r, inv0_r;
  logic         err0_r;

  logic [W-1:0] r1, a1, hq1, iv1, qi1;
  logic         err_d1 [W];

  logic [W:0]   tsum_w;
  logic [W-1:0] t_r, a_t_r, hq_t_r, iv_t_r, qi_t_r;
  logic         err_t_r;

  logic [W-1:0]      tq2, qi2;
  logic [SIDE_W-1:0] side_d [W];
  logic [W-1:0]      a2, hq2, iv2;
  logic              err2;

  logic [W:0]   s_w;
  logic [W-1:0] s_r, tq_r, iv_x1_r, qi_x1_r;
  logic         err_x1_r;
  logic [W-1:0] x_r, iv_x2_r, qi_x2_r;
  logic         err_x2_r;

  logic [W-1:0] res;
  logic         err_d3 [W];

  assign en        = !vld_r[LAT-1] || out_tready;
  assign in_tready = en;

  assign c_in   = in_tdata[W-1:0];
  assign cl_in  = in_tdata[2*W-1:W];
  assign qi_in  = in_tdata[3*W-1:2*W];
  assign inv_in = in_tdata[4*W-1:3*W];

  assign h_w = ql_r >> 1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ql_r <= W'(LAST_MODULUS_RESET);
    end else if (cfg_wen) begin
      ql_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_tvalid};
    end
  end

  // Input stage
  always_ff @(posedge clk) begin
    if (en) begin
      c0_r   <= c_in;
      cl0_r  <= cl_in;
      qi0_r  <= qi_in;
      inv0_r <= inv_in;
      err0_r <= (c_in >= qi_in) || (cl_in >= ql_r);
    end
  end

  rrdl_mod_reduce #(.W(W)) u_red_last (
    .clk(clk), .en(en), .a_i(cl0_r), .m_i(ql_r), .r_o(r1), .m_o()
  );
  rrdl_mod_reduce #(.W(W)) u_red_res (
    .clk(clk), .en(en), .a_i(c0_r), .m_i(qi0_r), .r_o(a1), .m_o(qi1)
  );
  rrdl_mod_reduce #(.W(W)) u_red_half (
    .clk(clk), .en(en), .a_i(h_w), .m_i(qi0_r), .r_o(hq1), .m_o()
  );
  rrdl_mod_reduce #(.W(W)) u_red_inv (
    .clk(clk), .en(en), .a_i(inv0_r), .m_i(qi0_r), .r_o(iv1), .m_o()
  );

  always_ff @(posedge clk) begin
    if (en) begin
      err_d1[0] <= err0_r;
      for (int s = 1; s < W; s++) begin
        err_d1[s] <= err_d1[s-1];
      end
    end
  end

  // Rounding offset: t = (last residue + h) mod last modulus
  assign tsum_w = {1'b0, r1} + {1'b0, h_w};

  always_ff @(posedge clk) begin
    if (en) begin
      if (tsum_w >= {1'b0, ql_r}) begin
        t_r <= W'(tsum_w - {1'b0, ql_r});
      end else begin
        t_r <= tsum_w[W-1:0];
      end
      a_t_r   <= a1;
      hq_t_r  <= hq1;
      iv_t_r  <= iv1;
      qi_t_r  <= qi1;
      err_t_r <= err_d1[W-1];
    end
  end

  rrdl_mod_reduce #(.W(W)) u_red_t (
    .clk(clk), .en(en), .a_i(t_r), .m_i(qi_t_r), .r_o(tq2), .m_o(qi2)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      side_d[0] <= {err_t_r, iv_t_r, hq_t_r, a_t_r};
      for (int s = 1; s < W; s++) begin
        side_d[s] <= side_d[s-1];
      end
    end
  end

  assign a2   = side_d[W-1][W-1:0];
  assign hq2  = side_d[W-1][2*W-1:W];
  assign iv2  = side_d[W-1][3*W-1:2*W];
  assign err2 = side_d[W-1][3*W];

  assign s_w = {1'b0, a2} + {1'b0, hq2};

  always_ff @(posedge clk) begin
    if (en) begin
      if (s_w >= {1'b0, qi2}) begin
        s_r <= W'(s_w - {1'b0, qi2});
      end else begin
        s_r <= s_w[W-1:0];
      end
      tq_r     <= tq2;
      iv_x1_r  <= iv2;
      qi_x1_r  <= qi2;
      err_x1_r <= err2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (s_r >= tq_r) begin
        x_r <= s_r - tq_r;
      end else begin
        x_r <= s_r + (qi_x1_r - tq_r);
      end
      iv_x2_r  <= iv_x1_r;
      qi_x2_r  <= qi_x1_r;
      err_x2_r <= err_x1_r;
    end
  end

  rrdl_mod_mul #(.W(W)) u_mul (
    .clk(clk), .en(en), .a_i(x_r), .b_i(iv_x2_r), .m_i(qi_x2_r), .r_o(res)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      err_d3[0] <= err_x2_r;
      for (int s = 1; s < W; s++) begin
        err_d3[s] <= err_d3[s-1];
      end
    end
  end

  assign out_tvalid = vld_r[LAT-1];
  assign out_tdata  = OUT_TW'(res);
  assign out_tuser  = err_d3[W-1];

endmodule

// ----- hdl/rrdl_checker.sv -----
module rrdl_checker #(
  parameter int MODULUS_BITS = 62
) (
  input logic clk,
  input logic rst_n,
  input logic in_tvalid,
  input logic in_tready,
  input logic out_tvalid,
  input logic out_tready,
  input logic [((MODULUS_BITS+7)/8)*8-1:0] out_tdata,
  input logic out_tuser
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // Input side advances exactly when the output register can move
  a_ready_link: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("in_tready does not follow output stall");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result present after reset");

  // No request accepted means the pipeline input stage stays empty, so nothing
  // new appears in an idle cycle following reset
  a_no_phantom: assert property (@(posedge clk)
    !rst_n ##1 (rst_n && !(in_tvalid && in_tready)) |-> !out_tvalid)
    else $error("result appeared without request");

endmodule

bind rns_rescale_drop_last_modulus_top rrdl_checker #(.MODULUS_BITS(MODULUS_BITS)) u_rrdl_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .out_tuser(out_tuser)
);

// ----- tb/sv/rns_rescale_drop_last_modulus_top_tb.sv -----
`timescale 1ns / 100ps

module rns_rescale_drop_last_modulus_top_tb;
  localparam int MB = 62;
  localparam int IN_W = ((4*MB+7)/8)*8;
  localparam int OUT_W = ((MB+7)/8)*8;
  localparam int LATENCY = 3*MB+4;
  localparam longint CYCLE_LIMIT = 2000000;
  localparam logic [MB-1:0] MAX_VAL = {MB{1'b1}};

  typedef struct packed {
    logic [MB-1:0] rescaled;
    logic          range_err;
  } rescale_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic out_tuser;
  logic cfg_wen = 1'b0;
  logic [MB-1:0] cfg_wdata = '0;

  logic [MB-1:0] last_mod_shadow;
  rescale_result_t pending_results[$];
  int mismatch_count = 0;
  longint cycle_count = 0;
  bit stall_enable = 1'b1;

  rns_rescale_drop_last_modulus_top #(.MODULUS_BITS(MB)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic logic [MB:0] mod_of(logic [MB:0] a, logic [MB-1:0] m);
    if (m == 0) return '0;
    return a % m;
  endfunction

  function automatic rescale_result_t predict_rescale(logic [MB-1:0] c, logic [MB-1:0] c_last,
                                                     logic [MB-1:0] qi, logic [MB-1:0] inv);
    rescale_result_t r;
    logic [MB:0] h, t, x;
    logic [2*MB+1:0] prod;
    r.range_err = (c >= qi) || (c_last >= last_mod_shadow);
    h = '0;
    t = '0;
    r.rescaled = '0;
    if (last_mod_shadow != 0) begin
      h = {1'b0, last_mod_shadow >> 1};
      t = mod_of(mod_of(c_last, last_mod_shadow) + h, last_mod_shadow);
    end
    if (qi != 0) begin
      x = mod_of(mod_of(c, qi) + mod_of(h, qi), qi);
      x = mod_of(x + qi - mod_of(t, qi), qi);
      prod = x * mod_of(inv, qi);
      r.rescaled = MB'(prod % qi);
    end
    return r;
  endfunction

  task automatic send_request(logic [MB-1:0] c, logic [MB-1:0] c_last,
                              logic [MB-1:0] qi, logic [MB-1:0] inv);
    in_tdata <= IN_W'({inv, qi, c_last, c});
    in_tvalid <= 1'b1;
    pending_results.push_back(predict_rescale(c, c_last, qi, inv));
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    // random burst gaps
    if ($urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic go_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic write_last_modulus(logic [MB-1:0] v);
    cfg_wen <= 1'b1;
    cfg_wdata <= v;
    last_mod_shadow = v;
    @(posedge clk);
    cfg_wen <= 1'b0;
  endtask

  function automatic logic [MB-1:0] rand_val();
    logic [MB-1:0] v;
    v = MB'({$urandom, $urandom});
    case ($urandom_range(0, 3))
      0: v = v >> $urandom_range(0, MB-1);
      1: v = MB'($urandom_range(0, 8));
      default: ;
    endcase
    return v;
  endfunction

  // receiver stall pattern
  always @(posedge clk) begin
    if (!stall_enable) out_tready <= 1'b1;
    else out_tready <= (cycle_count % 64 < 40) ? 1'b1 : ($urandom_range(0, 2) == 0);
  end

  always @(posedge clk) begin
    rescale_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: rescaled_residue %0h", out_tdata[MB-1:0]);
        mismatch_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_tdata[MB-1:0] !== exp_r.rescaled) begin
          $error("rescaled_residue expected %0h actual %0h", exp_r.rescaled,
                 out_tdata[MB-1:0]);
          mismatch_count++;
        end
        if (out_tuser !== exp_r.range_err) begin
          $error("range_error expected %0b actual %0b", exp_r.range_err, out_tuser);
          mismatch_count++;
        end
      end
    end
  end

  task automatic test_directed();
    send_request(0, 0, 7, 1);
    send_request(6, 1, 7, 4);
    send_request(MAX_VAL - 1, 1, MAX_VAL, MAX_VAL - 1);
    send_request(MAX_VAL, 2, MAX_VAL, 3);
    send_request(5, 0, 0, 3);
    send_request(0, 0, 1, 1);
    send_request(3, 0, 11, 20);
    send_request(MAX_VAL, MAX_VAL, 2, MAX_VAL);
    go_idle();
    write_last_modulus(0);
    send_request(4, 0, 9, 2);
    send_request(4, 5, 9, 2);
    go_idle();
    write_last_modulus(MAX_VAL);
    send_request(3, MAX_VAL - 1, 13, 5);
    send_request(MAX_VAL - 2, MAX_VAL, MAX_VAL - 1, MAX_VAL - 3);
    send_request(0, 0, 3, 2);
    go_idle();
    write_last_modulus(1);
    send_request(2, 0, 5, 1);
    send_request(2, 1, 5, 1);
    go_idle();
  endtask

  task automatic test_random_phase(logic [MB-1:0] lm, int n);
    logic [MB-1:0] qi, c, cl, inv;
    write_last_modulus(lm);
    repeat (n) begin
      qi = rand_val();
      if ($urandom_range(0, 9) != 0) begin
        if (qi < 2) qi = MB'(2 + $urandom_range(0, 100));
        c = rand_val() % qi;
        cl = (lm != 0) ? rand_val() % lm : '0;
        inv = 1 + rand_val() % (qi - 1);
      end else begin
        c = rand_val();
        cl = rand_val();
        inv = rand_val();
      end
      send_request(c, cl, qi, inv);
    end
    go_idle();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    last_mod_shadow = 2;
    @(posedge clk);
    test_directed();
    test_random_phase(2, 200);
    test_random_phase(MAX_VAL, 250);
    test_random_phase(MB'({$urandom, $urandom}), 250);
    stall_enable = 1'b0;
    test_random_phase(3, 200);
    stall_enable = 1'b1;
    test_random_phase(MB'($urandom_range(2, 1000)), 300);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
